@@ src/ttts_pkg.sv @@
// Package for the two-tape Turing step block: widths, command and status codes,
// request and queue entry types. No dependencies.
`default_nettype none
package ttts_pkg;
	localparam int RULE_ENTRIES = 64;
	localparam int TAPE_CELLS   = 256;
	localparam int STATE_COUNT  = 16;
	localparam int RULE_AW      = $clog2(RULE_ENTRIES);
	localparam int TAPE_AW      = $clog2(TAPE_CELLS);
	localparam int RULE_W       = 44;
	localparam logic [7:0] BLANK_SYMBOL = 8'h23;

	typedef enum logic [2:0] {
		CMD_LOAD    = 3'd0,
		CMD_WRITE   = 3'd1,
		CMD_RESTART = 3'd2,
		CMD_STEP    = 3'd3,
		CMD_READ    = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FINAL   = 3'd1,
		ST_BLOCKED = 3'd2,
		ST_RANGE   = 3'd3,
		ST_STOPPED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MV_STAY  = 2'd0,
		MV_RIGHT = 2'd1,
		MV_LEFT  = 2'd2
	} move_t;

	typedef struct packed {
		logic [3:0] st;
		logic [7:0] sa;
		logic [7:0] sb;
		logic [3:0] go;
		logic [7:0] pa;
		logic [1:0] ma;
		logic [7:0] pb;
		logic [1:0] mb;
	} rule_t;

	typedef enum logic [2:0] {
		OP_NOP   = 3'd0,
		OP_CELLW = 3'd1,
		OP_RESET = 3'd2,
		OP_STEP  = 3'd3,
		OP_CELLR = 3'd4,
		OP_BAD   = 3'd5
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       sel;
		logic [7:0] pos;
		logic [7:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] state;
		logic [7:0] head_a;
		logic [7:0] head_b;
		logic [7:0] rd;
	} res_t;
endpackage
`default_nettype wire

@@ src/ttts_ram.sv @@
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ttts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ src/ttts_front.sv @@
// Front part: accepts requests, writes rule entries, classifies every request into a
// two-entry queue. Depends on ttts_pkg and ttts_ram.
`default_nettype none
module ttts_front import ttts_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [2:0]          command,
	input  wire logic [7:0]          slot,
	input  wire logic                tape_select,
	input  wire logic [RULE_W-1:0]   rule_in,
	input  wire logic [7:0]          cell_value,
	input  wire logic                back_busy,
	output logic                     q_valid,
	output req_t                     q_data,
	input  wire logic                q_pop,
	input  wire logic [RULE_AW-1:0]  rule_raddr,
	output logic [RULE_W-1:0]        rule_rdata
);
	req_t       buf_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, rule_we;
	req_t       req;

	// hold a table load until every earlier request has been carried out
	assign in_ready = (cnt_q != 2'd2)
	                  && !(command == CMD_LOAD && (cnt_q != 2'd0 || back_busy));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = buf_q[rd_q];
	assign rule_we  = push && (command == CMD_LOAD) && ({1'b0, slot} < 9'(RULE_ENTRIES));

	always_comb begin
		req.sel   = tape_select;
		req.pos   = slot;
		req.value = cell_value;
		unique case (command)
			CMD_LOAD:    req.op = ({1'b0, slot} < 9'(RULE_ENTRIES)) ? OP_NOP : OP_BAD;
			CMD_WRITE:   req.op = OP_CELLW;
			CMD_RESTART: req.op = OP_RESET;
			CMD_STEP:    req.op = OP_STEP;
			CMD_READ:    req.op = OP_CELLR;
			default:     req.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	ttts_ram #(.WIDTH(RULE_W), .DEPTH(RULE_ENTRIES)) u_rules (
		.clk   (clk),
		.we    (rule_we),
		.waddr (slot[RULE_AW-1:0]),
		.wdata (rule_in),
		.raddr (rule_raddr),
		.rdata (rule_rdata)
	);
endmodule
`default_nettype wire

@@ src/ttts_back.sv @@
// Back part: carries out queued requests against the tapes and machine state,
// scanning rule entries in order and firing the first match. Depends on ttts_pkg and ttts_ram.
`default_nettype none
module ttts_back import ttts_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [3:0]         start_state,
	input  wire logic [15:0]        final_mask,
	input  wire logic [6:0]         entries_used,
	input  wire logic               q_valid,
	input  wire req_t               q_data,
	output logic                    q_pop,
	output logic                    busy,
	output logic [RULE_AW-1:0]      rule_raddr,
	input  wire logic [RULE_W-1:0]  rule_rdata,
	output logic                    res_valid,
	output res_t                    res,
	input  wire logic               res_ready
);
	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_TREAD = 7'b0000100,
		S_TWAIT = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_CHECK = 7'b0100000,
		S_FIRE  = 7'b1000000
	} fsm_t;

	fsm_t                 fsm_q;
	logic [TAPE_AW:0]     clr_q;
	logic [3:0]           state_q;
	logic [7:0]           ha_q, hb_q;
	logic                 run_q;
	logic [7:0]           syma_q, symb_q;
	logic [RULE_AW:0]     idx_q;
	logic [RULE_AW:0]     lim;
	req_t                 cur_q;
	rule_t                rule;
	logic                 ta_we, tb_we;
	logic [TAPE_AW-1:0]   ta_wa, tb_wa, ta_ra, tb_ra;
	logic [7:0]           ta_wd, tb_wd, ta_rd, tb_rd;
	logic                 out_free;
	logic [7:0]           na, nb;
	logic                 oka, okb, hit, fin;

	assign rule     = rule_t'(rule_rdata);
	assign out_free = !res_valid || res_ready;
	assign lim      = (entries_used > 7'(RULE_ENTRIES)) ? (RULE_AW+1)'(RULE_ENTRIES)
	                                                    : (RULE_AW+1)'(entries_used);
	assign rule_raddr = idx_q[RULE_AW-1:0];
	assign ta_ra    = (fsm_q == S_IDLE) ? q_data.pos : ha_q;
	assign tb_ra    = (fsm_q == S_IDLE) ? q_data.pos : hb_q;
	assign hit      = (rule.st == state_q) && (rule.sa == syma_q) && (rule.sb == symb_q);
	assign q_pop    = (fsm_q == S_IDLE) && q_valid
	                  && (out_free || (q_data.op == OP_STEP && run_q));
	assign busy     = (fsm_q != S_IDLE);

	always_comb begin
		oka = 1'b1;
		na  = ha_q;
		if (rule.ma == MV_RIGHT) begin
			if (ha_q == 8'(TAPE_CELLS-1)) oka = 1'b0; else na = ha_q + 8'd1;
		end else if (rule.ma == MV_LEFT) begin
			if (ha_q == 8'd0) oka = 1'b0; else na = ha_q - 8'd1;
		end
		okb = 1'b1;
		nb  = hb_q;
		if (rule.mb == MV_RIGHT) begin
			if (hb_q == 8'(TAPE_CELLS-1)) okb = 1'b0; else nb = hb_q + 8'd1;
		end else if (rule.mb == MV_LEFT) begin
			if (hb_q == 8'd0) okb = 1'b0; else nb = hb_q - 8'd1;
		end
		fin = final_mask[rule.go];
	end

	always_comb begin
		ta_we = 1'b0; tb_we = 1'b0;
		ta_wa = ha_q; tb_wa = hb_q;
		ta_wd = rule.pa; tb_wd = rule.pb;
		unique case (fsm_q)
			S_CLEAR: begin
				ta_we = 1'b1; tb_we = 1'b1;
				ta_wa = clr_q[TAPE_AW-1:0]; tb_wa = clr_q[TAPE_AW-1:0];
				ta_wd = BLANK_SYMBOL; tb_wd = BLANK_SYMBOL;
			end
			S_IDLE: begin
				ta_wa = q_data.pos; tb_wa = q_data.pos;
				ta_wd = q_data.value; tb_wd = q_data.value;
				ta_we = q_pop && q_data.op == OP_CELLW && !q_data.sel;
				tb_we = q_pop && q_data.op == OP_CELLW && q_data.sel;
			end
			S_FIRE: begin
				ta_we = 1'b1; tb_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fsm_q == S_TWAIT) begin
			syma_q <= ta_rd;
			symb_q <= tb_rd;
		end
		if (q_pop) cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q     <= S_CLEAR;
			clr_q     <= '0;
			state_q   <= 4'd0;
			ha_q      <= 8'd1;
			hb_q      <= 8'd1;
			run_q     <= 1'b1;
			idx_q     <= '0;
			res_valid <= 1'b0;
			res       <= '0;
		end else begin
			if (res_valid && res_ready) res_valid <= 1'b0;
			unique case (fsm_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (TAPE_AW+1)'(TAPE_CELLS-1)) fsm_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_valid && q_data.op == OP_STEP && run_q) begin
						fsm_q <= S_TREAD;
					end else if (q_pop) begin
						res_valid  <= 1'b1;
						res.status <= ST_OK;
						res.rd     <= 8'd0;
						res.state  <= state_q;
						res.head_a <= ha_q;
						res.head_b <= hb_q;
						unique case (q_data.op)
							OP_BAD:   res.status <= ST_RANGE;
							OP_STEP:  res.status <= ST_STOPPED;
							OP_CELLR: fsm_q <= S_TWAIT;
							OP_RESET: begin
								state_q <= start_state;
								ha_q <= 8'd1; hb_q <= 8'd1; run_q <= 1'b1;
								res.state <= start_state;
								res.head_a <= 8'd1; res.head_b <= 8'd1;
							end
							default: ;
						endcase
						if (q_data.op == OP_CELLR) res_valid <= 1'b0;
					end
				end
				S_TREAD: begin
					fsm_q <= S_TWAIT;
					idx_q <= '0;
				end
				S_TWAIT: begin
					if (cur_q.op == OP_CELLR) begin
						res_valid <= 1'b1;
						res.rd    <= cur_q.sel ? tb_rd : ta_rd;
						fsm_q     <= S_IDLE;
					end else begin
						fsm_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (idx_q >= lim) begin
						if (out_free) begin
							run_q      <= 1'b0;
							res_valid  <= 1'b1;
							res.status <= ST_BLOCKED;
							res.rd     <= 8'd0;
							res.state  <= state_q;
							res.head_a <= ha_q;
							res.head_b <= hb_q;
							fsm_q      <= S_IDLE;
						end
					end else begin
						fsm_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (hit) fsm_q <= S_FIRE;
					else begin
						idx_q <= idx_q + 1'b1;
						fsm_q <= S_SCAN;
					end
				end
				S_FIRE: begin
					if (out_free) begin
						state_q    <= rule.go;
						ha_q       <= na;
						hb_q       <= nb;
						res_valid  <= 1'b1;
						res.rd     <= 8'd0;
						res.state  <= rule.go;
						res.head_a <= na;
						res.head_b <= nb;
						if (!oka || !okb) begin
							res.status <= ST_RANGE;
							run_q <= 1'b0;
						end else if (fin) begin
							res.status <= ST_FINAL;
							run_q <= 1'b0;
						end else begin
							res.status <= ST_OK;
						end
						fsm_q <= S_IDLE;
					end
				end
				default: fsm_q <= S_IDLE;
			endcase
		end
	end

	logic ta_wg, tb_wg;
	assign ta_wg = ta_we && !(fsm_q == S_FIRE && !out_free);
	assign tb_wg = tb_we && !(fsm_q == S_FIRE && !out_free);

	ttts_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape_a (
		.clk(clk), .we(ta_wg), .waddr(ta_wa), .wdata(ta_wd), .raddr(ta_ra), .rdata(ta_rd)
	);
	ttts_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape_b (
		.clk(clk), .we(tb_wg), .waddr(tb_wa), .wdata(tb_wd), .raddr(tb_ra), .rdata(tb_rd)
	);
endmodule
`default_nettype wire

@@ src/two_tape_turing_step.sv @@
// Two-tape Turing step block. Loads, cell writes, restarts and steps of a stopped
// machine are answered from idle; a cell read waits on a tape RAM read; a step
// scans rule entries in order, one rule RAM read and compare each, and fires the
// first match. A new item is taken only when the last is done; a two-entry queue
// decouples input from work, and a table load waits until the queue is empty and
// the back part is idle. Reset: asynchronous; then both tapes are blanked
// before any queued item runs. Depends on ttts_pkg, ttts_front, ttts_back.
`default_nettype none
module two_tape_turing_step import ttts_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  command,
	input  wire logic [7:0]  slot,
	input  wire logic        tape_select,
	input  wire logic [3:0]  match_state,
	input  wire logic [7:0]  match_sym_a,
	input  wire logic [7:0]  match_sym_b,
	input  wire logic [3:0]  goto_state,
	input  wire logic [7:0]  put_sym_a,
	input  wire logic [1:0]  move_a,
	input  wire logic [7:0]  put_sym_b,
	input  wire logic [1:0]  move_b,
	input  wire logic [7:0]  cell_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [3:0]       machine_state,
	output logic [7:0]       head_a_pos,
	output logic [7:0]       head_b_pos,
	output logic [7:0]       read_value
);
	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_FINAL = 2'd1;
	localparam logic [1:0] REG_USED  = 2'd2;

	logic [3:0]          start_q;
	logic [15:0]         final_q;
	logic [6:0]          used_q;
	logic                q_valid, q_pop;
	logic                back_busy;
	req_t                q_data;
	logic [RULE_AW-1:0]  raddr;
	logic [RULE_W-1:0]   rdata;
	res_t                res;
	rule_t               rin;

	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[3:2])
			REG_START: prdata = {28'd0, start_q};
			REG_FINAL: prdata = {16'd0, final_q};
			REG_USED:  prdata = {25'd0, used_q};
			default:   prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			final_q <= '0;
			used_q  <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_START: start_q <= pwdata[3:0];
				REG_FINAL: final_q <= pwdata[15:0];
				REG_USED:  used_q  <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	assign rin = '{st: match_state, sa: match_sym_a, sb: match_sym_b, go: goto_state,
	               pa: put_sym_a, ma: move_a, pb: put_sym_b, mb: move_b};

	ttts_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.command(command), .slot(slot), .tape_select(tape_select), .rule_in(rin),
		.cell_value(cell_value), .back_busy(back_busy), .q_valid(q_valid),
		.q_data(q_data), .q_pop(q_pop), .rule_raddr(raddr), .rule_rdata(rdata)
	);

	ttts_back u_back (
		.clk(clk), .arst_n(arst_n), .start_state(start_q), .final_mask(final_q),
		.entries_used(used_q), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
		.busy(back_busy), .rule_raddr(raddr), .rule_rdata(rdata), .res_valid(out_valid),
		.res(res), .res_ready(out_ready)
	);

	assign status        = res.status;
	assign machine_state = res.state;
	assign head_a_pos    = res.head_a;
	assign head_b_pos    = res.head_b;
	assign read_value    = res.rd;

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_value))
		else $error("result changed while stalled");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> read_value == 8'd0)
		else $error("read value on non-read result");
`endif
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Testbench for two_tape_turing_step: directed and random requests, scoreboard
// with its own machine model, random idling on both channels, APB setup.
// Depends on ttts_pkg and the two_tape_turing_step RTL.
`timescale 1ns / 100ps
module tb;
	import ttts_pkg::*;

	localparam logic [3:0] REG_START = 4'h0;
	localparam logic [3:0] REG_FINAL = 4'h4;
	localparam logic [3:0] REG_USED  = 4'h8;
	localparam logic [1:0] MV_HOLD   = 2'd3;
	localparam logic [7:0] SYM_A     = 8'h61;
	localparam logic [7:0] SYM_B     = 8'h62;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] slot;
		logic       sel;
		logic [3:0] mst;
		logic [7:0] msa;
		logic [7:0] msb;
		logic [3:0] go;
		logic [7:0] pa;
		logic [1:0] ma;
		logic [7:0] pb;
		logic [1:0] mb;
		logic [7:0] cval;
	} item_t;

	class turing_scoreboard;
		rule_t rules[RULE_ENTRIES];
		logic [7:0] tape_a[TAPE_CELLS];
		logic [7:0] tape_b[TAPE_CELLS];
		logic [3:0] state, start_state;
		logic [7:0] head_a, head_b;
		bit running;
		logic [15:0] final_mask;
		logic [6:0] used;
		res_t pending[$];
		int errors, accepted, checked;
		int seen[8];

		function new();
			foreach (tape_a[i]) begin
				tape_a[i] = BLANK_SYMBOL;
				tape_b[i] = BLANK_SYMBOL;
			end
			state = 0;
			start_state = 0;
			head_a = 1;
			head_b = 1;
			running = 1;
			final_mask = 0;
			used = 0;
		endfunction

		function void set_reg(logic [3:0] addr, logic [31:0] v);
			case (addr)
				REG_START: start_state = v[3:0];
				REG_FINAL: final_mask = v[15:0];
				REG_USED: used = v[6:0];
				default: ;
			endcase
		endfunction

		function bit shift_head(inout logic [7:0] h, input logic [1:0] mv);
			if (mv == MV_RIGHT) begin
				if (h == 8'hFF) return 0;
				h = h + 1;
			end else if (mv == MV_LEFT) begin
				if (h == 0) return 0;
				h = h - 1;
			end
			return 1;
		endfunction

		function void note(item_t it);
			res_t r;
			rule_t e;
			int n, hit;
			bit ok_a, ok_b;
			r = '0;
			accepted++;
			case (it.command)
				CMD_LOAD: begin
					if (it.slot < RULE_ENTRIES)
						rules[it.slot] = '{it.mst, it.msa, it.msb, it.go, it.pa, it.ma,
							it.pb, it.mb};
					else
						r.status = ST_RANGE;
				end
				CMD_WRITE: begin
					if (it.sel) tape_b[it.slot] = it.cval;
					else tape_a[it.slot] = it.cval;
				end
				CMD_READ: r.rd = it.sel ? tape_b[it.slot] : tape_a[it.slot];
				CMD_RESTART: begin
					state = start_state;
					head_a = 1;
					head_b = 1;
					running = 1;
				end
				CMD_STEP: begin
					if (!running) begin
						r.status = ST_STOPPED;
					end else begin
						n = (used > RULE_ENTRIES) ? RULE_ENTRIES : used;
						hit = -1;
						for (int i = 0; i < n; i++) begin
							if (rules[i].st == state && rules[i].sa == tape_a[head_a] &&
									rules[i].sb == tape_b[head_b]) begin
								hit = i;
								break;
							end
						end
						if (hit < 0) begin
							running = 0;
							r.status = ST_BLOCKED;
						end else begin
							e = rules[hit];
							tape_a[head_a] = e.pa;
							tape_b[head_b] = e.pb;
							state = e.go;
							ok_a = shift_head(head_a, e.ma);
							ok_b = shift_head(head_b, e.mb);
							if (!ok_a || !ok_b) begin
								running = 0;
								r.status = ST_RANGE;
							end else if (state < STATE_COUNT && final_mask[state]) begin
								running = 0;
								r.status = ST_FINAL;
							end
						end
					end
				end
				default: ;
			endcase
			r.state = state;
			r.head_a = head_a;
			r.head_b = head_b;
			pending.push_back(r);
		endfunction

		function void cmp(string name, int exp, int act);
			if (exp != act) begin
				$error("%s: expected %0d, got %0d", name, exp, act);
				errors++;
			end
		endfunction

		function void check(res_t got);
			res_t exp;
			if (pending.size() == 0) begin
				$error("result with nothing outstanding");
				errors++;
				return;
			end
			exp = pending.pop_front();
			checked++;
			seen[exp.status]++;
			cmp("status", exp.status, got.status);
			cmp("machine_state", exp.state, got.state);
			cmp("head_a_pos", exp.head_a, got.head_a);
			cmp("head_b_pos", exp.head_b, got.head_b);
			cmp("read_value", exp.rd, got.rd);
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = 0;
	logic [31:0] pwdata = 0, prdata;
	logic pready;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic [2:0] command = 0;
	logic [7:0] slot = 0;
	logic tape_select = 0;
	logic [3:0] match_state = 0, goto_state = 0;
	logic [7:0] match_sym_a = 0, match_sym_b = 0, put_sym_a = 0, put_sym_b = 0;
	logic [7:0] cell_value = 0;
	logic [1:0] move_a = 0, move_b = 0;
	logic [2:0] status;
	logic [3:0] machine_state;
	logic [7:0] head_a_pos, head_b_pos, read_value;

	turing_scoreboard sb;
	int tx_idle = 0, rx_idle = 0;
	bit loaded[RULE_ENTRIES];
	int eu = 0;

	two_tape_turing_step dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_idle);

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note('{command, slot, tape_select, match_state, match_sym_a, match_sym_b,
					goto_state, put_sym_a, move_a, put_sym_b, move_b, cell_value});
			if (out_valid && out_ready)
				sb.check('{status, machine_state, head_a_pos, head_b_pos, read_value});
		end
	end

	task automatic send(item_t it);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		command <= it.command;
		slot <= it.slot;
		tape_select <= it.sel;
		match_state <= it.mst;
		match_sym_a <= it.msa;
		match_sym_b <= it.msb;
		goto_state <= it.go;
		put_sym_a <= it.pa;
		move_a <= it.ma;
		put_sym_b <= it.pb;
		move_b <= it.mb;
		cell_value <= it.cval;
		in_valid <= 1;
		if (it.command == CMD_LOAD && it.slot < RULE_ENTRIES) loaded[it.slot] = 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic [3:0] a, logic [31:0] v);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= a;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		sb.set_reg(a, v);
		psel <= 0;
		penable <= 0;
	endtask

	task automatic configure(logic [3:0] s, logic [15:0] m, logic [6:0] u);
		drain();
		apb_write(REG_START, 32'(s));
		apb_write(REG_FINAL, 32'(m));
		apb_write(REG_USED, 32'(u));
		eu = u;
	endtask

	function automatic item_t noise_item();
		item_t it;
		it = item_t'($bits(item_t)'({$urandom, $urandom}));
		return it;
	endfunction

	function automatic item_t rule_item(logic [7:0] s, logic [3:0] st, logic [7:0] sa,
			logic [7:0] sbm, logic [3:0] go, logic [7:0] pa, logic [1:0] ma,
			logic [7:0] pb, logic [1:0] mb);
		item_t it;
		it = noise_item();
		it.command = CMD_LOAD;
		it.slot = s;
		it.mst = st;
		it.msa = sa;
		it.msb = sbm;
		it.go = go;
		it.pa = pa;
		it.ma = ma;
		it.pb = pb;
		it.mb = mb;
		return it;
	endfunction

	function automatic item_t cmd_item(logic [2:0] c, logic sel = 0, logic [7:0] s = 0,
			logic [7:0] v = 0);
		item_t it;
		it = noise_item();
		it.command = c;
		it.sel = sel;
		it.slot = s;
		it.cval = v;
		return it;
	endfunction

	function automatic logic [7:0] pick_sym();
		case ($urandom_range(9))
			0, 1, 2: return BLANK_SYMBOL;
			3, 4: return SYM_A;
			5, 6: return SYM_B;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [3:0] pick_state();
		return ($urandom_range(3) != 0) ? 4'($urandom_range(3)) : 4'($urandom);
	endfunction

	function automatic item_t next_item();
		item_t it;
		int r, n;
		it = noise_item();
		r = $urandom_range(99);
		if (r < 45) begin
			it.command = CMD_STEP;
			n = (eu > RULE_ENTRIES) ? RULE_ENTRIES : eu;
			for (int i = 0; i < n; i++) begin
				if (!loaded[i]) begin
					it.command = CMD_LOAD;
					it.slot = 8'(i);
					break;
				end
			end
		end else if (r < 60) begin
			it.command = CMD_LOAD;
			it.slot = ($urandom_range(9) != 0) ? 8'($urandom_range(RULE_ENTRIES - 1))
			                                   : 8'($urandom);
		end else if (r < 72) begin
			it.command = CMD_WRITE;
			it.cval = pick_sym();
			if ($urandom_range(4) != 0) it.slot = 8'($urandom_range(7));
		end else if (r < 82) begin
			it.command = CMD_RESTART;
		end else if (r < 92) begin
			it.command = CMD_READ;
			if ($urandom_range(1) != 0) it.slot = 8'($urandom_range(7));
		end else begin
			it.command = 3'($urandom_range(CMD_READ + 1, 7));
		end
		if (it.command == CMD_LOAD && $urandom_range(4) != 0) begin
			it.mst = pick_state();
			it.go = pick_state();
			it.msa = pick_sym();
			it.msb = pick_sym();
			it.pa = pick_sym();
			it.pb = pick_sym();
		end
		return it;
	endfunction

	initial begin
		#20ms;
		$display("tb failed");
		$finish;
	end

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1;
		configure(0, 16'h0004, 0);
		send(cmd_item(CMD_STEP));
		send(cmd_item(CMD_STEP));
		send(cmd_item(CMD_RESTART));
		send(rule_item(64, 0, 0, 0, 0, 0, MV_STAY, 0, MV_STAY));
		send(rule_item(255, 0, 0, 0, 0, 0, MV_STAY, 0, MV_STAY));
		send(rule_item(0, 0, BLANK_SYMBOL, BLANK_SYMBOL, 1, SYM_A, MV_RIGHT, SYM_B, MV_LEFT));
		send(rule_item(1, 1, BLANK_SYMBOL, BLANK_SYMBOL, 3, 8'hFF, MV_HOLD, 8'h00, MV_LEFT));
		send(rule_item(2, 0, SYM_A, SYM_B, 2, BLANK_SYMBOL, MV_STAY, BLANK_SYMBOL, MV_STAY));
		send(rule_item(3, 0, SYM_A, SYM_B, 5, SYM_B, MV_RIGHT, SYM_A, MV_RIGHT));
		send(rule_item(63, 4'hF, 8'hFF, 8'hFF, 4'hF, 8'hFF, MV_HOLD, 8'hFF, MV_HOLD));
		configure(0, 16'h0004, 4);
		send(cmd_item(CMD_STEP));
		send(cmd_item(CMD_STEP));
		send(cmd_item(CMD_STEP));
		send(cmd_item(CMD_RESTART));
		send(cmd_item(CMD_STEP));
		send(cmd_item(CMD_WRITE, 0, 0, 8'hFF));
		send(cmd_item(CMD_WRITE, 1, 255, 8'h00));
		send(cmd_item(CMD_READ, 0, 0));
		send(cmd_item(CMD_READ, 1, 255));
		send(cmd_item(CMD_READ, 1, 1));
		send(cmd_item(3'(CMD_READ + 1)));
		send(cmd_item(3'h7, 1, 8'hFF, 8'hFF));
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: configure(0, 16'h0000, 7'd127);
				1: configure(4'hF, 16'hFFFF, 64);
				default: configure(4'($urandom_range(3)), 16'($urandom) & 16'hFF00,
					7'($urandom_range(1, RULE_ENTRIES)));
			endcase
			tx_idle = (p < 2) ? 17 : (p < 4) ? 85 : 0;
			rx_idle = (p < 2) ? 85 : (p < 4) ? 17 : 0;
			repeat (234) send(next_item());
		end
		drain();
		repeat (140) @(posedge clk);
		if (sb.pending.size() != 0) begin
			$error("%0d results never arrived", sb.pending.size());
			sb.errors++;
		end
		$display("Ran %0d requests over 8 register settings, checked %0d results.",
			sb.accepted, sb.checked);
		$display("Outcomes: moved/done %0d, final %0d, blocked %0d, out of range %0d, stopped %0d",
			sb.seen[ST_OK], sb.seen[ST_FINAL], sb.seen[ST_BLOCKED], sb.seen[ST_RANGE],
			sb.seen[ST_STOPPED]);
		if (sb.errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
